FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: rtl/hnc_pkg.sv
// types, codes and tables of the hd44780 nibble command sequencer
// no dependencies
package hnc_pkg;

    localparam logic [2:0] KIND_INIT  = 3'd0;
    localparam logic [2:0] KIND_RAW   = 3'd1;
    localparam logic [2:0] KIND_CLEAR = 3'd2;
    localparam logic [2:0] KIND_CURSOR = 3'd3;
    localparam logic [2:0] KIND_LINE  = 3'd4;
    localparam logic [2:0] KIND_CHAR  = 3'd5;

    localparam logic [1:0] WAIT_HOLD   = 2'd0;
    localparam logic [1:0] WAIT_SETTLE = 2'd1;
    localparam logic [1:0] WAIT_LONG   = 2'd2;

    localparam logic       REG_LINE_WIDTH   = 1'b0;
    localparam logic [4:0] LINE_WIDTH_RESET = 5'd16;
    localparam logic [4:0] MAX_WIDTH        = 5'd20;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] CHAR_BLANK   = 8'h20;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_CR      = 8'h0d;
    localparam logic [7:0] CHAR_LF      = 8'h0a;

    localparam logic [3:0] INIT_LAST_STEP = 4'd11;

    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_INIT,
        JOB_LINE
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic       rs;
        logic [7:0] data;
        logic [1:0] wait_lo;
        logic [4:0] width;
    } t_job;

    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic [1:0] wait_after;
        logic       powerup_wait;
        logic       last;
    } t_strobe;

    function automatic logic [7:0] row_addr(input logic [1:0] row);
        logic [7:0] addr;
        case (row)
            2'd0:    addr = 8'h80;
            2'd1:    addr = 8'hc0;
            2'd2:    addr = 8'h94;
            default: addr = 8'hd4;
        endcase
        return addr;
    endfunction

    // three wake-up nibbles, 4-bit switch, then 0x28 0x0c 0x01 0x06
    function automatic logic [3:0] init_nibble(input logic [3:0] step);
        logic [3:0] nib;
        case (step)
            4'd0, 4'd1, 4'd2: nib = 4'h3;
            4'd3, 4'd4:       nib = 4'h2;
            4'd5:             nib = 4'h8;
            4'd7:             nib = 4'hc;
            4'd9:             nib = 4'h1;
            4'd11:            nib = 4'h6;
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

    function automatic logic [1:0] init_wait(input logic [3:0] step);
        logic [1:0] w;
        if (step < 4'd4 || step[0]) begin
            w = WAIT_LONG;
        end else begin
            w = WAIT_HOLD;
        end
        return w;
    endfunction

endpackage

FILE: rtl/hnc_fifo.sv
// small register queue used between the sequencer stages and at the output
// depends on nothing
module hnc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/hnc_front.sv
// request classifier: keeps the line state and turns requests into jobs
// depends on hnc_pkg
module hnc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [2:0]        i_kind,
    input  logic [7:0]        i_value,
    input  logic              i_reg_select,
    input  logic [4:0]        i_line_width,
    output logic              o_job_push,
    output hnc_pkg::t_job     o_job
);

    logic [4:0] r_chars_seen, n_chars_seen;
    logic       r_line_open, n_line_open;
    logic [4:0] eff_width;
    logic       emit;

    assign eff_width = (i_line_width > hnc_pkg::MAX_WIDTH) ? hnc_pkg::MAX_WIDTH
                                                           : i_line_width;
    assign o_job_push = i_accept && emit;

    always_comb begin
        n_chars_seen = r_chars_seen;
        n_line_open  = r_line_open;
        emit         = 1'b0;
        o_job.kind    = hnc_pkg::JOB_BYTE;
        o_job.rs      = 1'b0;
        o_job.data    = i_value;
        o_job.wait_lo = hnc_pkg::WAIT_SETTLE;
        o_job.width   = eff_width;
        unique case (i_kind)
            hnc_pkg::KIND_INIT: begin
                emit        = 1'b1;
                n_line_open = 1'b0;
                o_job.kind  = hnc_pkg::JOB_INIT;
            end
            hnc_pkg::KIND_RAW: begin
                emit        = 1'b1;
                n_line_open = 1'b0;
                o_job.rs    = i_reg_select;
            end
            hnc_pkg::KIND_CLEAR: begin
                emit          = 1'b1;
                n_line_open   = 1'b0;
                o_job.data    = hnc_pkg::CMD_CLEAR;
                o_job.wait_lo = hnc_pkg::WAIT_LONG;
            end
            hnc_pkg::KIND_CURSOR: begin
                emit        = 1'b1;
                n_line_open = 1'b0;
                o_job.data  = i_value | hnc_pkg::CMD_SET_DDRAM;
            end
            hnc_pkg::KIND_LINE: begin
                emit         = 1'b1;
                n_line_open  = 1'b1;
                n_chars_seen = '0;
                o_job.kind   = hnc_pkg::JOB_LINE;
                o_job.data   = hnc_pkg::row_addr(i_value[1:0]);
            end
            hnc_pkg::KIND_CHAR: begin
                o_job.rs = 1'b1;
                if (r_line_open) begin
                    if (i_value == hnc_pkg::CHAR_NUL) begin
                        n_line_open = 1'b0;
                    end else if (r_chars_seen < eff_width) begin
                        n_chars_seen = r_chars_seen + 1'b1;
                        emit = (i_value != hnc_pkg::CHAR_CR) &&
                               (i_value != hnc_pkg::CHAR_LF);
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars_seen <= '0;
            r_line_open  <= 1'b0;
        end else if (i_accept) begin
            r_chars_seen <= n_chars_seen;
            r_line_open  <= n_line_open;
        end
    end

endmodule

FILE: rtl/hnc_back.sv
// strobe sequencer: while the output queue has room, walks the head job one nibble strobe per cycle
// depends on hnc_pkg
module hnc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_empty,
    input  hnc_pkg::t_job     i_job,
    output logic              o_job_pop,
    input  logic              i_out_full,
    output logic              o_out_push,
    output hnc_pkg::t_strobe  o_strobe
);

    logic [5:0] r_step, n_step;
    logic [4:0] byte_idx;
    logic       row_cmd;
    logic [7:0] line_byte;
    logic       emit;

    assign byte_idx  = r_step[5:1];
    assign row_cmd   = (byte_idx == '0) ||
                       ({1'b0, byte_idx} == ({1'b0, i_job.width} + 6'd1));
    assign line_byte = row_cmd ? i_job.data : hnc_pkg::CHAR_BLANK;
    assign emit      = !i_job_empty && !i_out_full;
    assign o_out_push = emit;
    assign o_job_pop  = emit && o_strobe.last;

    always_comb begin
        o_strobe = '0;
        unique case (i_job.kind)
            hnc_pkg::JOB_BYTE: begin
                o_strobe.rs         = i_job.rs;
                o_strobe.nibble     = r_step[0] ? i_job.data[3:0] : i_job.data[7:4];
                o_strobe.wait_after = r_step[0] ? i_job.wait_lo : hnc_pkg::WAIT_HOLD;
                o_strobe.last       = r_step[0];
            end
            hnc_pkg::JOB_INIT: begin
                o_strobe.nibble       = hnc_pkg::init_nibble(r_step[3:0]);
                o_strobe.wait_after   = hnc_pkg::init_wait(r_step[3:0]);
                o_strobe.powerup_wait = (r_step == '0);
                o_strobe.last         = (r_step[3:0] == hnc_pkg::INIT_LAST_STEP);
            end
            hnc_pkg::JOB_LINE: begin
                o_strobe.rs         = !row_cmd;
                o_strobe.nibble     = r_step[0] ? line_byte[3:0] : line_byte[7:4];
                o_strobe.wait_after = r_step[0] ? hnc_pkg::WAIT_SETTLE
                                                : hnc_pkg::WAIT_HOLD;
                o_strobe.last       = r_step[0] && row_cmd && (byte_idx != '0);
            end
            default: begin
                o_strobe.last = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (emit) begin
            n_step = o_strobe.last ? '0 : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

FILE: rtl/hd44780_nibble_command_sequencer_core.sv
// hd44780 4-bit nibble command sequencer, top level
// depends on hnc_pkg, hnc_fifo, hnc_front, hnc_back
//
// Requests enter on a queue-style port (push/full) as kind, value and
// reg_select. Each request becomes zero or more strobe words (RS, nibble,
// wait code, power-up flag, last flag) read out through empty/pop.
// A byte is two words, init is twelve, a line start is 2*width+4.
// Line width is set through the APB port at address 0 (5 bits, reset 16).
// An accepted request is registered in the job queue, and its words are
// registered in the output queue. The strobe sequencer emits one word per
// cycle while a job is waiting and the output queue has room. A job queue of
// QUEUE_DEPTH entries lets requests be taken while a long one is still
// being expanded; requests that give no words are taken at one per cycle
// while that queue has room.
// Reset empties both queues, closes any open line and restores the width.
// When pop stays low, the two-word output queue fills, the sequencer holds,
// then the job queue fills and full rises; nothing is dropped.
module hd44780_nibble_command_sequencer_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_value,
    input  logic        i_reg_select,
    output logic        empty,
    input  logic        pop,
    output logic        o_reg_select_res,
    output logic [3:0]  o_nibble,
    output logic [1:0]  o_wait_after,
    output logic        o_powerup_wait,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0]       r_line_width;
    logic             accept;
    logic             job_push, job_pop, job_full, job_empty;
    hnc_pkg::t_job    job_in, job_out;
    logic             out_push, out_full;
    hnc_pkg::t_strobe strobe_in, strobe_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == hnc_pkg::REG_LINE_WIDTH) ? {27'd0, r_line_width} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= hnc_pkg::LINE_WIDTH_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == hnc_pkg::REG_LINE_WIDTH) begin
            r_line_width <= pwdata[4:0];
        end
    end

    assign full   = job_full;
    assign accept = push && !job_full;

    hnc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .i_reg_select (i_reg_select),
        .i_line_width (r_line_width),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    hnc_fifo #(
        .WIDTH ($bits(hnc_pkg::t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_out)
    );

    hnc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_strobe    (strobe_in)
    );

    hnc_fifo #(
        .WIDTH ($bits(hnc_pkg::t_strobe)),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (strobe_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (strobe_out)
    );

    assign o_reg_select_res = strobe_out.rs;
    assign o_nibble         = strobe_out.nibble;
    assign o_wait_after     = strobe_out.wait_after;
    assign o_powerup_wait   = strobe_out.powerup_wait;
    assign o_last           = strobe_out.last;

endmodule

FILE: rtl/hnc_checker.sv
// port-level checks of the nibble command sequencer, bound to the top level
// depends on assert_macros.svh, hnc_pkg and hd44780_nibble_command_sequencer_core
`include "assert_macros.svh"

module hnc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        o_reg_select_res,
    input logic [3:0]  o_nibble,
    input logic [1:0]  o_wait_after,
    input logic        o_powerup_wait,
    input logic        o_last
);

    // queues come out of reset empty
    `ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> empty)

    // power-up word is the first wake-up nibble
    `ASSERT_CLK(a_powerup_word, i_clk, i_rst_n,
        (!empty && o_powerup_wait) |-> (!o_reg_select_res && o_nibble == 4'h3 &&
        o_wait_after == hnc_pkg::WAIT_LONG))

    // a request always ends on a low nibble with a settle or long wait
    `ASSERT_CLK(a_last_settles, i_clk, i_rst_n,
        (!empty && o_last) |-> (o_wait_after != hnc_pkg::WAIT_HOLD))

    // data words never ask for the long wait
    `ASSERT_CLK(a_data_short_wait, i_clk, i_rst_n,
        (!empty && o_reg_select_res) |-> (o_wait_after == hnc_pkg::WAIT_HOLD ||
        o_wait_after == hnc_pkg::WAIT_SETTLE))

endmodule

bind hd44780_nibble_command_sequencer_core hnc_checker u_hnc_checker (.*);

FILE: tb/sv/hd44780_nibble_command_sequencer_core_tb.sv
// self-checking testbench for the hd44780 nibble command sequencer core
// depends on hnc_pkg and hd44780_nibble_command_sequencer_core
// requests and strobe words are predicted in the bench and checked word by word

module hd44780_nibble_command_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam logic [3:0] INIT_WAKE     = 4'h3;
    localparam logic [3:0] INIT_FOUR_BIT = 4'h2;
    localparam logic [7:0] FUNCTION_SET  = 8'h28;
    localparam logic [7:0] DISPLAY_ON    = 8'h0c;
    localparam logic [7:0] ENTRY_MODE    = 8'h06;
    localparam logic [3:0][7:0] ROW_BASE = {8'hd4, 8'h94, 8'hc0, 8'h80};
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] value;
        logic       rs;
    } t_lcd_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_kind = hnc_pkg::KIND_INIT;
    logic [7:0]  i_value = 8'h00;
    logic        i_reg_select = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_reg_select_res;
    logic [3:0]  o_nibble;
    logic [1:0]  o_wait_after;
    logic        o_powerup_wait;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    t_lcd_request     request_q[$];
    hnc_pkg::t_strobe pending_strobes[$];
    int               requests_left = 0;
    int               mismatches = 0;
    int               cycle_count = 0;
    int               send_gap = 0;
    int               recv_gap = 0;
    bit               req_taken = 1'b0;
    bit               calm = 1'b0;

    logic [4:0]   tb_width = hnc_pkg::LINE_WIDTH_RESET;
    logic [4:0]   chars_used = 5'd0;
    logic         line_active = 1'b0;

    hd44780_nibble_command_sequencer_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_kind           (i_kind),
        .i_value          (i_value),
        .i_reg_select     (i_reg_select),
        .empty            (empty),
        .pop              (pop),
        .o_reg_select_res (o_reg_select_res),
        .o_nibble         (o_nibble),
        .o_wait_after     (o_wait_after),
        .o_powerup_wait   (o_powerup_wait),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [4:0] effective_width();
        return (tb_width > hnc_pkg::MAX_WIDTH) ? hnc_pkg::MAX_WIDTH : tb_width;
    endfunction

    task automatic add_nibble(input logic rs, input logic [3:0] nib, input logic [1:0] wt,
                              input logic pw);
        hnc_pkg::t_strobe s;
        s.rs = rs;
        s.nibble = nib;
        s.wait_after = wt;
        s.powerup_wait = pw;
        s.last = 1'b0;
        pending_strobes.push_back(s);
    endtask

    task automatic add_byte(input logic rs, input logic [7:0] b, input logic [1:0] wait_lo);
        add_nibble(rs, b[7:4], hnc_pkg::WAIT_HOLD, 1'b0);
        add_nibble(rs, b[3:0], wait_lo, 1'b0);
    endtask

    task automatic expand_request(input logic [2:0] kind, input logic [7:0] value,
                                  input logic rs);
        int               start_size;
        hnc_pkg::t_strobe tail;
        logic [4:0]       w;
        start_size = pending_strobes.size();
        w = effective_width();
        if (kind > hnc_pkg::KIND_CHAR) return;
        if (kind != hnc_pkg::KIND_CHAR) line_active = 1'b0;
        case (kind)
            hnc_pkg::KIND_INIT: begin
                add_nibble(1'b0, INIT_WAKE, hnc_pkg::WAIT_LONG, 1'b1);
                add_nibble(1'b0, INIT_WAKE, hnc_pkg::WAIT_LONG, 1'b0);
                add_nibble(1'b0, INIT_WAKE, hnc_pkg::WAIT_LONG, 1'b0);
                add_nibble(1'b0, INIT_FOUR_BIT, hnc_pkg::WAIT_LONG, 1'b0);
                add_byte(1'b0, FUNCTION_SET, hnc_pkg::WAIT_LONG);
                add_byte(1'b0, DISPLAY_ON, hnc_pkg::WAIT_LONG);
                add_byte(1'b0, hnc_pkg::CMD_CLEAR, hnc_pkg::WAIT_LONG);
                add_byte(1'b0, ENTRY_MODE, hnc_pkg::WAIT_LONG);
            end
            hnc_pkg::KIND_RAW: begin
                add_byte(rs, value, hnc_pkg::WAIT_SETTLE);
            end
            hnc_pkg::KIND_CLEAR: begin
                add_byte(1'b0, hnc_pkg::CMD_CLEAR, hnc_pkg::WAIT_LONG);
            end
            hnc_pkg::KIND_CURSOR: begin
                add_byte(1'b0, value | hnc_pkg::CMD_SET_DDRAM, hnc_pkg::WAIT_SETTLE);
            end
            hnc_pkg::KIND_LINE: begin
                add_byte(1'b0, ROW_BASE[value[1:0]], hnc_pkg::WAIT_SETTLE);
                repeat (w) add_byte(1'b1, hnc_pkg::CHAR_BLANK, hnc_pkg::WAIT_SETTLE);
                add_byte(1'b0, ROW_BASE[value[1:0]], hnc_pkg::WAIT_SETTLE);
                line_active = 1'b1;
                chars_used = 5'd0;
            end
            default: begin
                if (!line_active) return;
                if (value == hnc_pkg::CHAR_NUL) begin
                    line_active = 1'b0;
                    return;
                end
                if (chars_used >= w) return;
                chars_used = chars_used + 5'd1;
                if (value == hnc_pkg::CHAR_CR || value == hnc_pkg::CHAR_LF) return;
                add_byte(1'b1, value, hnc_pkg::WAIT_SETTLE);
            end
        endcase
        if (pending_strobes.size() > start_size) begin
            tail = pending_strobes.pop_back();
            tail.last = 1'b1;
            pending_strobes.push_back(tail);
        end
    endtask

    task automatic queue_request(input logic [2:0] kind, input logic [7:0] value,
                                 input logic rs);
        t_lcd_request r;
        r.kind = kind;
        r.value = value;
        r.rs = rs;
        request_q.push_back(r);
        requests_left++;
    endtask

    task automatic gen_traffic(input int n);
        int         made;
        int         chars;
        logic [7:0] ch;
        logic [2:0] k;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 9) < 6) begin
                if ($urandom_range(0, 4) == 0) begin
                    queue_request(hnc_pkg::KIND_LINE, 8'($urandom), 1'($urandom));
                end else begin
                    queue_request(hnc_pkg::KIND_LINE, 8'($urandom_range(0, 3)), 1'($urandom));
                end
                made++;
                chars = $urandom_range(0, int'(effective_width()) + 3);
                repeat (chars) begin
                    case ($urandom_range(0, 19))
                        0: ch = hnc_pkg::CHAR_CR;
                        1: ch = hnc_pkg::CHAR_LF;
                        2: ch = 8'($urandom_range(1, 255));
                        default: ch = 8'($urandom_range(32, 126));
                    endcase
                    queue_request(hnc_pkg::KIND_CHAR, ch, 1'($urandom));
                    made++;
                end
                if ($urandom_range(0, 3) != 0) begin
                    queue_request(hnc_pkg::KIND_CHAR, hnc_pkg::CHAR_NUL, 1'($urandom));
                end
            end else begin
                k = 3'($urandom_range(0, 7));
                queue_request(k, 8'($urandom), 1'($urandom));
                if (k <= hnc_pkg::KIND_CHAR) made++;
            end
        end
    endtask

    task automatic program_width(input logic [4:0] w);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {hnc_pkg::REG_LINE_WIDTH, 2'b00};
        pwdata <= {27'd0, w};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tb_width = w;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[4:0] !== w) begin
            $error("line_width readback: expected %0d, got %0d", w, prdata[4:0]);
            mismatches++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle(input int settle);
        while (requests_left != 0 || pending_strobes.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin
        t_lcd_request r;
        if (push && !req_taken) begin
            push <= 1'b1;
        end else if (send_gap != 0) begin
            send_gap--;
            push <= 1'b0;
        end else if (!calm && request_q.size() != 0 && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 17) - 1;
            push <= 1'b0;
        end else if (request_q.size() != 0) begin
            r = request_q.pop_front();
            i_kind <= r.kind;
            i_value <= r.value;
            i_reg_select <= r.rs;
            push <= 1'b1;
        end else begin
            push <= 1'b0;
        end
    end

    // word receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            pop <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(1, 17) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // word checker and request predictor
    always @(posedge i_clk) begin
        hnc_pkg::t_strobe want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("hd44780_nibble_command_sequencer_core test failed");
            $finish;
        end
        if (i_rst_n && pop && !empty) begin
            if (pending_strobes.size() == 0) begin
                $error("unexpected word: rs %0b nibble %0h wait %0d", o_reg_select_res,
                       o_nibble, o_wait_after);
                mismatches++;
            end else begin
                want = pending_strobes.pop_front();
                if (o_reg_select_res !== want.rs) begin
                    $error("reg_select_res: expected %0b, got %0b", want.rs, o_reg_select_res);
                    mismatches++;
                end
                if (o_nibble !== want.nibble) begin
                    $error("nibble: expected %0h, got %0h", want.nibble, o_nibble);
                    mismatches++;
                end
                if (o_wait_after !== want.wait_after) begin
                    $error("wait_after: expected %0d, got %0d", want.wait_after, o_wait_after);
                    mismatches++;
                end
                if (o_powerup_wait !== want.powerup_wait) begin
                    $error("powerup_wait: expected %0b, got %0b", want.powerup_wait,
                           o_powerup_wait);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    mismatches++;
                end
            end
        end
        req_taken = i_rst_n && push && !full;
        if (req_taken) begin
            expand_request(i_kind, i_value, i_reg_select);
            requests_left--;
        end
    end

    initial begin
        int unsigned width_plan[5];
        width_plan[0] = hnc_pkg::MAX_WIDTH;
        width_plan[1] = 31;
        width_plan[2] = $urandom_range(2, 19);
        width_plan[3] = 1;
        width_plan[4] = $urandom_range(1, 20);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset width, every request kind
        queue_request(hnc_pkg::KIND_INIT, 8'h00, 1'b0);
        queue_request(hnc_pkg::KIND_RAW, 8'h00, 1'b0);
        queue_request(hnc_pkg::KIND_RAW, 8'hff, 1'b1);
        queue_request(hnc_pkg::KIND_CLEAR, 8'h00, 1'b1);
        queue_request(hnc_pkg::KIND_CURSOR, 8'h00, 1'b0);
        queue_request(hnc_pkg::KIND_CURSOR, 8'hff, 1'b1);
        queue_request(hnc_pkg::KIND_LINE, 8'h00, 1'b0);
        queue_request(hnc_pkg::KIND_CHAR, 8'h41, 1'b0);
        queue_request(hnc_pkg::KIND_CHAR, hnc_pkg::CHAR_CR, 1'b0);
        queue_request(hnc_pkg::KIND_CHAR, hnc_pkg::CHAR_LF, 1'b1);
        queue_request(hnc_pkg::KIND_CHAR, 8'h7e, 1'b0);
        queue_request(hnc_pkg::KIND_CHAR, hnc_pkg::CHAR_NUL, 1'b0);
        queue_request(hnc_pkg::KIND_CHAR, 8'h42, 1'b0);
        queue_request(KIND_SPARE_LO, 8'hff, 1'b1);
        queue_request(KIND_SPARE_HI, 8'h00, 1'b0);
        wait_idle(8);

        // narrowest line: full line, out-of-range row, cr taking a slot, close by other kind
        program_width(5'd1);
        @(posedge i_clk);
        queue_request(hnc_pkg::KIND_LINE, 8'hff, 1'b0);
        queue_request(hnc_pkg::KIND_CHAR, 8'h78, 1'b0);
        queue_request(hnc_pkg::KIND_CHAR, 8'h79, 1'b0);
        queue_request(hnc_pkg::KIND_CHAR, hnc_pkg::CHAR_NUL, 1'b0);
        queue_request(hnc_pkg::KIND_LINE, 8'h02, 1'b0);
        queue_request(hnc_pkg::KIND_CHAR, hnc_pkg::CHAR_CR, 1'b0);
        queue_request(hnc_pkg::KIND_CHAR, 8'h7a, 1'b0);
        queue_request(hnc_pkg::KIND_LINE, 8'h01, 1'b1);
        queue_request(hnc_pkg::KIND_RAW, 8'h41, 1'b1);
        queue_request(hnc_pkg::KIND_CHAR, 8'h71, 1'b0);
        wait_idle(8);

        foreach (width_plan[p]) begin
            program_width(5'(width_plan[p]));
            if (p == 4) calm = 1'b1;
            @(posedge i_clk);
            gen_traffic(34);
            wait_idle((p == 4) ? 20 : 8);
        end

        if (mismatches == 0) begin
            $display("hd44780_nibble_command_sequencer_core test passed");
        end else begin
            $display("hd44780_nibble_command_sequencer_core test failed");
        end
        $finish;
    end

endmodule
